// ===== rtl/rlcs_pkg.sv =====
`default_nettype none

package rlcs_pkg;

    // chain geometry
    localparam int LED_COUNT    = 4;
    localparam int BITS_PER_LED = 24;
    localparam int COLOR_W      = 24;
    localparam int LED_IDX_W    = 2;
    localparam int BIT_POS_W    = 5;

    // field and register widths
    localparam int FUNC_W      = 2;
    localparam int CHAN_W      = 8;
    localparam int BIT_TICKS_W = 8;
    localparam int LATCH_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // func codes on the input word
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_ONE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET_ALL = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH     = 3'd4;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_SET_ONE,
        KIND_SET_ALL,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [LED_IDX_W-1:0] led_index;
        logic [COLOR_W-1:0]   color;
    } item_t;

    // line_level sits in the lowest bit
    typedef struct packed {
        logic frame_pending;
        logic busy_res;
        logic line_level;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/rgb_led_chain_serializer_top.sv =====
`default_nettype none

// RGB LED chain serializer: keeps a GRB color for each of four LEDs and
// models the serial data line of the chain one tick word at a time.
//
// s_axis: input words. tuser = func (tick, set one LED, set all LEDs, other codes ignored).
//   A tick word advances the waveform by one time unit; a set word stores
//   a color and starts a frame when it is a real change (or the first write).
// m_axis: one result word per input word: line level, busy, frame pending.
// cfg: register writes (index, data), always ready; write only while idle.
//
// Path: an accepted word is written into the queue, then popped into the
// result register that drives m_axis_tvalid and m_axis_tdata.
// Throughput: one word per clock while m_axis is ready; the back end's state
// update is registered directly, so it then takes one queued word every cycle.
// A two-word queue sits between the input side and the back end, and the
// back end has a result register, so a stalled m_axis keeps the queue
// filling; s_axis_tready drops only once the queue is full.
// Reset: line idle, colors all ones and marked unknown, timing registers
// at their defaults (3/5 zero bit, 5/4 one bit, latch gap 400 ticks).

module rgb_led_chain_serializer_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [1:0] led_index, [9:2] green, [17:10] red, [25:18] blue, rest zero
    input  wire logic [31:0]                      s_axis_tdata,
    // [1:0] func
    input  wire logic [rlcs_pkg::FUNC_W-1:0]      s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [0] line_level, [1] busy_res, [2] frame_pending, rest zero
    output logic [7:0]                            m_axis_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [rlcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rlcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic              item_valid;
    logic              item_pop;
    rlcs_pkg::item_t   item;
    rlcs_pkg::result_t res;

    // config writes are always taken and land at the next clock edge
    assign cfg_ready = 1'b1;

    rlcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .func       (s_axis_tuser),
        .led_index  (s_axis_tdata[1:0]),
        .green      (s_axis_tdata[9:2]),
        .red        (s_axis_tdata[17:10]),
        .blue       (s_axis_tdata[25:18]),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    rlcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_valid  (m_axis_tvalid),
        .res        (res),
        .res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {5'b0, res};

endmodule

`default_nettype wire

// ===== rtl/rlcs_front.sv =====
`default_nettype none

module rlcs_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [rlcs_pkg::FUNC_W-1:0]     func,
    input  wire logic [rlcs_pkg::LED_IDX_W-1:0]  led_index,
    input  wire logic [rlcs_pkg::CHAN_W-1:0]     green,
    input  wire logic [rlcs_pkg::CHAN_W-1:0]     red,
    input  wire logic [rlcs_pkg::CHAN_W-1:0]     blue,
    output logic                                 item_valid,
    output rlcs_pkg::item_t                      item,
    input  wire logic                            item_pop
);

    rlcs_pkg::item_t q_reg [2];
    rlcs_pkg::item_t cls_item;
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push;

    // classify the incoming word
    always_comb
    begin
        cls_item.led_index = led_index;
        cls_item.color     = {green, red, blue};
        unique case (func)
            rlcs_pkg::FUNC_TICK:    cls_item.kind = rlcs_pkg::KIND_TICK;
            rlcs_pkg::FUNC_SET_ONE: cls_item.kind = rlcs_pkg::KIND_SET_ONE;
            rlcs_pkg::FUNC_SET_ALL: cls_item.kind = rlcs_pkg::KIND_SET_ALL;
            default:                cls_item.kind = rlcs_pkg::KIND_NOP;
        endcase
    end

    assign in_ready   = (count_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(item_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rlcs_back.sv =====
`default_nettype none

module rlcs_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    input  wire logic [rlcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rlcs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             item_valid,
    input  wire rlcs_pkg::item_t                  item,
    output logic                                  item_pop,
    output logic                                  res_valid,
    output rlcs_pkg::result_t                     res,
    input  wire logic                             res_ready
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_LATCH
    } phase_t;

    localparam int CW = rlcs_pkg::COLOR_W;
    localparam int TW = rlcs_pkg::BIT_TICKS_W;
    localparam int LW = rlcs_pkg::LATCH_W;

    // config
    logic [TW-1:0] zero_high_reg, zero_low_reg, one_high_reg, one_low_reg;
    logic [LW-1:0] latch_reg;

    // LED color state
    logic [CW-1:0] store_reg  [rlcs_pkg::LED_COUNT];
    logic [CW-1:0] store_next [rlcs_pkg::LED_COUNT];
    logic [rlcs_pkg::LED_COUNT-1:0] known_reg, known_next;

    // waveform state
    phase_t                          phase_reg, phase_next;
    logic [rlcs_pkg::LED_IDX_W-1:0]  led_reg, led_next;
    logic [rlcs_pkg::BIT_POS_W-1:0]  bit_reg, bit_next;
    logic [LW-1:0]                   count_reg, count_next;
    logic                            resend_reg, resend_next;
    logic                            cur_bit_reg, cur_bit_next;

    logic                 out_valid_reg;
    rlcs_pkg::result_t    out_reg, out_next;

    logic          changed_one, changed_all, request, start_frame, start_bit;
    logic [LW:0]   cnt_inc;
    logic [TW-1:0] bit_limit;
    logic [rlcs_pkg::BIT_POS_W-1:0] sample_idx;
    phase_t        shown;

    assign item_pop  = item_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        changed_one = !known_reg[item.led_index] || (store_reg[item.led_index] != item.color);
        changed_all = 1'b0;
        for (int i = 0; i < rlcs_pkg::LED_COUNT; i++)
        begin
            if (!known_reg[i] || (store_reg[i] != item.color))
            begin
                changed_all = 1'b1;
            end
        end
    end

    always_comb
    begin
        store_next   = store_reg;
        known_next   = known_reg;
        phase_next   = phase_reg;
        led_next     = led_reg;
        bit_next     = bit_reg;
        count_next   = count_reg;
        resend_next  = resend_reg;
        cur_bit_next = cur_bit_reg;
        request      = 1'b0;
        start_frame  = 1'b0;
        start_bit    = 1'b0;
        cnt_inc      = {1'b0, count_reg} + (LW+1)'(1);
        bit_limit    = 1'b0 ? one_high_reg : zero_high_reg;
        sample_idx   = '0;

        if (item_pop)
        begin
            unique case (item.kind)
                rlcs_pkg::KIND_TICK:
                begin
                    unique case (phase_reg)
                        PH_HIGH:
                        begin
                            bit_limit = cur_bit_reg ? one_high_reg : zero_high_reg;
                            if (cnt_inc >= (LW+1)'(bit_limit))
                            begin
                                phase_next = PH_LOW;
                                count_next = '0;
                            end
                            else
                            begin
                                count_next = cnt_inc[LW-1:0];
                            end
                        end
                        PH_LOW:
                        begin
                            bit_limit = cur_bit_reg ? one_low_reg : zero_low_reg;
                            if (cnt_inc >= (LW+1)'(bit_limit))
                            begin
                                if (bit_reg == rlcs_pkg::BIT_POS_W'(rlcs_pkg::BITS_PER_LED - 1))
                                begin
                                    bit_next = '0;
                                    if (led_reg == rlcs_pkg::LED_IDX_W'(rlcs_pkg::LED_COUNT - 1))
                                    begin
                                        led_next   = '0;
                                        phase_next = PH_LATCH;
                                        count_next = '0;
                                    end
                                    else
                                    begin
                                        led_next  = led_reg + rlcs_pkg::LED_IDX_W'(1);
                                        start_bit = 1'b1;
                                    end
                                end
                                else
                                begin
                                    bit_next  = bit_reg + rlcs_pkg::BIT_POS_W'(1);
                                    start_bit = 1'b1;
                                end
                            end
                            else
                            begin
                                count_next = cnt_inc[LW-1:0];
                            end
                        end
                        PH_LATCH:
                        begin
                            if (cnt_inc >= (LW+1)'(latch_reg))
                            begin
                                if (resend_reg)
                                begin
                                    resend_next = 1'b0;
                                    start_frame = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                    count_next = '0;
                                end
                            end
                            else
                            begin
                                count_next = cnt_inc[LW-1:0];
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                rlcs_pkg::KIND_SET_ONE:
                begin
                    if (changed_one)
                    begin
                        store_next[item.led_index] = item.color;
                        known_next[item.led_index] = 1'b1;
                        request                    = 1'b1;
                    end
                end
                rlcs_pkg::KIND_SET_ALL:
                begin
                    if (changed_all)
                    begin
                        for (int i = 0; i < rlcs_pkg::LED_COUNT; i++)
                        begin
                            store_next[i] = item.color;
                        end
                        known_next = '1;
                        request    = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // a change starts a frame now or is held for after the latch gap
        if (request)
        begin
            if (phase_reg == PH_IDLE)
            begin
                start_frame = 1'b1;
            end
            else
            begin
                resend_next = 1'b1;
            end
        end

        if (start_frame)
        begin
            led_next  = '0;
            bit_next  = '0;
            start_bit = 1'b1;
        end

        // bit value is read live from the store at the start of its high time
        if (start_bit)
        begin
            phase_next   = PH_HIGH;
            count_next   = '0;
            sample_idx   = rlcs_pkg::BIT_POS_W'(CW - 1) - bit_next;
            cur_bit_next = store_next[led_next][sample_idx];
        end

        shown = (item.kind == rlcs_pkg::KIND_TICK) ? phase_reg : phase_next;
        out_next.line_level    = (shown == PH_HIGH);
        out_next.busy_res      = (shown != PH_IDLE);
        out_next.frame_pending = resend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_high_reg <= TW'(3);
            zero_low_reg  <= TW'(5);
            one_high_reg  <= TW'(5);
            one_low_reg   <= TW'(4);
            latch_reg     <= LW'(400);
            for (int i = 0; i < rlcs_pkg::LED_COUNT; i++)
            begin
                store_reg[i] <= '1;
            end
            known_reg     <= '0;
            phase_reg     <= PH_IDLE;
            led_reg       <= '0;
            bit_reg       <= '0;
            count_reg     <= '0;
            resend_reg    <= 1'b0;
            cur_bit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    rlcs_pkg::CFG_ZERO_HIGH: zero_high_reg <= cfg_data[TW-1:0];
                    rlcs_pkg::CFG_ZERO_LOW:  zero_low_reg  <= cfg_data[TW-1:0];
                    rlcs_pkg::CFG_ONE_HIGH:  one_high_reg  <= cfg_data[TW-1:0];
                    rlcs_pkg::CFG_ONE_LOW:   one_low_reg   <= cfg_data[TW-1:0];
                    rlcs_pkg::CFG_LATCH:     latch_reg     <= cfg_data[LW-1:0];
                    default:
                    begin
                    end
                endcase
            end
            store_reg   <= store_next;
            known_reg   <= known_next;
            phase_reg   <= phase_next;
            led_reg     <= led_next;
            bit_reg     <= bit_next;
            count_reg   <= count_next;
            resend_reg  <= resend_next;
            cur_bit_reg <= cur_bit_next;
            if (item_pop)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sim/rgb_led_chain_serializer_top_test.sv =====
`timescale 1ns / 100ps

module rgb_led_chain_serializer_top_test;
    import rlcs_pkg::*;

    // generous cap on the length of the whole run
    localparam int unsigned CYCLE_LIMIT = 250000;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the LED chain waveform word by word and holds the
    // result words still owed by the block, oldest first.
    // ------------------------------------------------------------------
    class led_chain_scoreboard;
        typedef enum logic [1:0] {WAVE_IDLE, WAVE_HIGH, WAVE_LOW, WAVE_LATCH} wave_t;

        // timing registers
        bit [BIT_TICKS_W-1:0] zero_high;
        bit [BIT_TICKS_W-1:0] zero_low;
        bit [BIT_TICKS_W-1:0] one_high;
        bit [BIT_TICKS_W-1:0] one_low;
        bit [LATCH_W-1:0]     latch_len;

        // chain state
        bit [COLOR_W-1:0] color_store [LED_COUNT];
        bit               color_known [LED_COUNT];
        int unsigned      led_pos;
        int unsigned      bit_pos;
        int unsigned      tick_cnt;
        wave_t            phase;
        bit               resend;
        bit               cur_bit;

        result_t     words_due [$];
        int unsigned mismatches;
        int unsigned words_checked;

        function new();
            zero_high = 8'd3;
            zero_low  = 8'd5;
            one_high  = 8'd5;
            one_low   = 8'd4;
            latch_len = 16'd400;
            for (int i = 0; i < LED_COUNT; i++)
            begin
                color_store[i] = '1;
                color_known[i] = 1'b0;
            end
            led_pos       = 0;
            bit_pos       = 0;
            tick_cnt      = 0;
            phase         = WAVE_IDLE;
            resend        = 1'b0;
            cur_bit       = 1'b0;
            mismatches    = 0;
            words_checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ZERO_HIGH: zero_high = data[BIT_TICKS_W-1:0];
                CFG_ZERO_LOW:  zero_low  = data[BIT_TICKS_W-1:0];
                CFG_ONE_HIGH:  one_high  = data[BIT_TICKS_W-1:0];
                CFG_ONE_LOW:   one_low   = data[BIT_TICKS_W-1:0];
                CFG_LATCH:     latch_len = data;
                default: ;
            endcase
        endfunction

        // bit level is taken from the store when its high time begins
        function void start_bit();
            phase    = WAVE_HIGH;
            tick_cnt = 0;
            cur_bit  = color_store[led_pos][BITS_PER_LED - 1 - bit_pos];
        endfunction

        function void start_frame();
            led_pos = 0;
            bit_pos = 0;
            start_bit();
        endfunction

        function void request_frame();
            if (phase == WAVE_IDLE)
                start_frame();
            else
                resend = 1'b1;
        endfunction

        function void advance_tick();
            int unsigned lim;
            case (phase)
                WAVE_HIGH:
                begin
                    lim = cur_bit ? one_high : zero_high;
                    tick_cnt++;
                    if (tick_cnt >= lim)
                    begin
                        phase    = WAVE_LOW;
                        tick_cnt = 0;
                    end
                end
                WAVE_LOW:
                begin
                    lim = cur_bit ? one_low : zero_low;
                    tick_cnt++;
                    if (tick_cnt >= lim)
                    begin
                        bit_pos++;
                        if (bit_pos >= BITS_PER_LED)
                        begin
                            bit_pos = 0;
                            led_pos++;
                        end
                        if (led_pos >= LED_COUNT)
                        begin
                            led_pos  = 0;
                            phase    = WAVE_LATCH;
                            tick_cnt = 0;
                        end
                        else
                            start_bit();
                    end
                end
                WAVE_LATCH:
                begin
                    tick_cnt++;
                    if (tick_cnt >= latch_len)
                    begin
                        if (resend)
                        begin
                            resend = 1'b0;
                            start_frame();
                        end
                        else
                        begin
                            phase    = WAVE_IDLE;
                            tick_cnt = 0;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // accepted input word: update the chain and queue the result it owes
        function void accept_word(kind_t f, bit [1:0] idx, bit [COLOR_W-1:0] grb);
            wave_t   shown;
            bit      changed;
            result_t r;
            shown   = phase;
            changed = 1'b0;
            case (f)
                KIND_TICK: advance_tick();
                KIND_SET_ONE:
                begin
                    if (!color_known[idx] || color_store[idx] != grb)
                    begin
                        color_store[idx] = grb;
                        color_known[idx] = 1'b1;
                        request_frame();
                    end
                end
                KIND_SET_ALL:
                begin
                    for (int i = 0; i < LED_COUNT; i++)
                        if (!color_known[i] || color_store[i] != grb)
                            changed = 1'b1;
                    if (changed)
                    begin
                        for (int i = 0; i < LED_COUNT; i++)
                        begin
                            color_store[i] = grb;
                            color_known[i] = 1'b1;
                        end
                        request_frame();
                    end
                end
                default: ;
            endcase
            // a tick reports the tick just spent, anything else the state after it
            if (f != KIND_TICK)
                shown = phase;
            r.line_level    = (shown == WAVE_HIGH);
            r.busy_res      = (shown != WAVE_IDLE);
            r.frame_pending = resend;
            words_due.push_back(r);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            mismatches++;
            $display("result word %0d: %s (got %0d, want %0d)", words_checked, what, got,
                     want);
        endtask

        task check_word(logic [7:0] word);
            result_t got;
            result_t want;
            got = result_t'(word[2:0]);
            if (words_due.size() == 0)
            begin
                report_mismatch("result word with nothing due", word, 0);
                return;
            end
            want = words_due.pop_front();
            if (got.line_level !== want.line_level)
                report_mismatch("line_level", got.line_level, want.line_level);
            if (got.busy_res !== want.busy_res)
                report_mismatch("busy_res", got.busy_res, want.busy_res);
            if (got.frame_pending !== want.frame_pending)
                report_mismatch("frame_pending", got.frame_pending, want.frame_pending);
            words_checked++;
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;
    logic [FUNC_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    led_chain_scoreboard sb = new();
    int unsigned         burst_left;
    int unsigned         cycles;

    rgb_led_chain_serializer_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Every process samples at the rising edge, before the block's own
    // updates land, and drives with nonblocking assignments.

    // run watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: checks each accepted word, and stalls in one of four
    // randomly picked modes (always ready, coin flip, fixed 2-of-3
    // pattern, mostly stalled).
    initial
    begin
        int unsigned cyc;
        int unsigned mode;
        m_axis_tready <= 1'b0;
        cyc  = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata);
            if (cyc % 48 == 0)
                mode = $urandom_range(0, 3);
            cyc++;
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= (cyc % 3 != 0);
                default: m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // One input word; returns at the edge where it is taken.
    // tdata: [1:0] led_index, [9:2] green, [17:10] red, [25:18] blue
    task automatic put_word(input kind_t f, input logic [1:0] idx,
                            input logic [COLOR_W-1:0] grb);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= f;
        s_axis_tdata  <= {6'b0, grb[7:0], grb[15:8], grb[23:16], idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.accept_word(f, idx, grb);
    endtask

    // bursts of back-to-back words, sometimes long, with random gaps
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 7);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic send(input kind_t f, input logic [1:0] idx, input logic [COLOR_W-1:0] grb);
        put_word(f, idx, grb);
        pace_sender();
    endtask

    // hold the sender until every owed result word has come back
    task automatic drain();
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        while (sb.words_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_timing(input int unsigned zh, input int unsigned zl,
                                input int unsigned oh, input int unsigned ol,
                                input int unsigned latch);
        write_reg(CFG_ZERO_HIGH, CFG_DATA_W'(zh));
        write_reg(CFG_ZERO_LOW, CFG_DATA_W'(zl));
        write_reg(CFG_ONE_HIGH, CFG_DATA_W'(oh));
        write_reg(CFG_ONE_LOW, CFG_DATA_W'(ol));
        write_reg(CFG_LATCH, CFG_DATA_W'(latch));
    endtask

    // color update: often a repeat of what the LED holds (no frame when a
    // known LED is set alone), else an extreme or a random color
    function automatic void pick_update(output kind_t f, output logic [1:0] idx,
                                        output logic [COLOR_W-1:0] grb);
        f   = ($urandom_range(0, 2) == 0) ? KIND_SET_ALL : KIND_SET_ONE;
        idx = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 4))
            0, 1:    grb = sb.color_store[idx];
            2:       grb = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            default: grb = COLOR_W'($urandom);
        endcase
    endfunction

    // Episodes: a few color updates, then a run of ticks, at times long
    // enough to carry a frame through to the latch gap and back to idle,
    // with the odd update or ignored word inside the run.
    task automatic random_run(input int unsigned n_items);
        int unsigned      sent;
        int unsigned      tick_run;
        int unsigned      pause_at;
        int unsigned      r;
        bit               paused;
        kind_t            f;
        logic [1:0]       idx;
        logic [COLOR_W-1:0] grb;
        sent     = 0;
        tick_run = 0;
        paused   = 1'b0;
        pause_at = $urandom_range(1, n_items - 1);
        while (sent < n_items)
        begin
            if (!paused && sent >= pause_at)
            begin
                paused = 1'b1;
                drain();
            end
            r = $urandom_range(0, 99);
            if (tick_run == 0 || r < 4)
            begin
                pick_update(f, idx, grb);
                send(f, idx, grb);
                sent++;
                if (tick_run == 0 && $urandom_range(0, 1) == 0)
                    tick_run = $urandom_range(8, 260);
            end
            else if (r < 6)
            begin
                // ignored word: not counted
                send(KIND_NOP, 2'($urandom_range(0, 3)), COLOR_W'($urandom));
            end
            else
            begin
                send(KIND_TICK, 2'($urandom_range(0, 3)), COLOR_W'($urandom));
                sent++;
                tick_run--;
            end
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_TICK;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_ZERO_HIGH;
        cfg_data      <= '0;
        burst_left    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: default timing
        send(KIND_NOP, 2'd3, 24'h5A5A5A);          // ignored while idle
        send(KIND_SET_ONE, 2'd0, 24'hFFFFFF);      // equals reset color, still a first write
        send(KIND_SET_ONE, 2'd0, 24'hFFFFFF);      // true repeat, nothing new
        repeat (6) send(KIND_TICK, 2'd0, 24'h000000);
        send(KIND_SET_ONE, 2'd1, 24'h000000);      // change mid-frame -> pending
        send(KIND_SET_ONE, 2'd2, 24'hA55A0F);
        send(KIND_SET_ONE, 2'd3, 24'h123456);
        send(KIND_SET_ALL, 2'd0, 24'h000000);      // differs on some LEDs
        send(KIND_SET_ALL, 2'd2, 24'h000000);      // every LED known and equal
        send(KIND_NOP, 2'd0, 24'hFFFFFF);          // ignored while busy
        send(KIND_SET_ONE, 2'd3, 24'hFFFFFF);
        send(KIND_SET_ONE, 2'd0, 24'h00FF00);      // live read of LED 0 bits
        repeat (6) send(KIND_TICK, 2'd3, 24'hFFFFFF);
        drain();

        // shortest timing: zero high as 0 (acts as one tick), upper data
        // bits on an 8-bit register ignored, latch gap of one tick
        write_timing(0, 1, 16'hFF01, 2, 1);
        for (int i = CFG_LATCH + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom)); // unused indexes do nothing
        random_run(300);
        drain();

        repeat (2)
        begin
            write_timing($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3),
                         $urandom_range(1, 3), $urandom_range(1, 40));
            random_run(250);
            drain();
        end

        // longest timing: only part of a frame fits
        write_timing(255, 255, 255, 255, 65535);
        random_run(80);
        drain();

        write_timing($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 4),
                     $urandom_range(1, 4), $urandom_range(1, 300));
        random_run(250);
        drain();

        // let any stray word show up
        repeat (10) @(posedge clk);
        if (sb.words_due.size() != 0)
            sb.report_mismatch("result words never arrived", sb.words_due.size(), 0);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== rgb_led_chain_serializer_top.f =====
rtl/rlcs_pkg.sv
rtl/rlcs_front.sv
rtl/rlcs_back.sv
rtl/rgb_led_chain_serializer_top.sv
sim/rgb_led_chain_serializer_top_test.sv
